// ===== src/text_to_signed_integer_assert.svh =====
// assertion macros for the text to signed integer converter
// no dependencies; included by the modules that check their own logic
`ifndef TEXT_TO_SIGNED_INTEGER_ASSERT_SVH
`define TEXT_TO_SIGNED_INTEGER_ASSERT_SVH

`ifndef SYNTHESIS

`define TTI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tti assertion failed");

`define TTI_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tti assertion failed");

`define TTI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tti assertion failed");

`else

`define TTI_ASSERT(label, clk, rst, prop)

`define TTI_ASSERT_IMPLY(label, clk, rst, pre, post)

`define TTI_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== src/tti_pkg.sv =====
// types and constants shared by the text to signed integer converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_LEAD,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_BASE = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   localparam logic [1:0] CSR_NUMBER_BASE   = 2'd0;
   localparam logic [1:0] CSR_LOWEST_VALUE  = 2'd1;
   localparam logic [1:0] CSR_HIGHEST_VALUE = 2'd2;
   localparam logic [1:0] CSR_DIGIT_LIMIT   = 2'd3;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [5:0] BASE_DETECT  = 6'd0;
   localparam logic [5:0] BASE_UNARY   = 6'd1;
   localparam logic [5:0] BASE_OCTAL   = 6'd8;
   localparam logic [5:0] BASE_DECIMAL = 6'd10;
   localparam logic [5:0] BASE_HEX     = 6'd16;
   localparam logic [5:0] BASE_MAX     = 6'd36;

   localparam logic [5:0] LETTER_OFFSET = 6'd10;
   localparam logic [5:0] DIGIT_NONE    = 6'd36;

   localparam logic [63:0] RESET_LOWEST_VALUE  = 64'h8000_0000_0000_0000;
   localparam logic [62:0] RESET_HIGHEST_VALUE = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [6:0]  RESET_DIGIT_LIMIT   = 7'd64;

   typedef struct packed {
      logic [5:0]  number_base;
      logic [63:0] lowest_value;
      logic [62:0] highest_value;
      logic [6:0]  digit_limit;
   } cfg_type;

   typedef struct packed {
      logic        stop;
      logic        range_error;
      logic [63:0] next_acc;
   } digit_type;

   typedef struct packed {
      logic        emit;
      logic [1:0]  status;
      logic [63:0] value;
      logic [15:0] chars_consumed;
   } result_type;

endpackage

`default_nettype wire

// ===== src/tti_req_if.sv =====
// input channel: one character per item with a string start flag
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface tti_req_if;
   logic       valid;
   logic       ready;
   logic       string_start;
   logic [7:0] character;

   modport source (output valid, output string_start, output character, input ready);
   modport sink (input valid, input string_start, input character, output ready);
endinterface

`default_nettype wire

// ===== src/tti_rsp_if.sv =====
// result channel: status, signed value and characters consumed per string
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface tti_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [63:0] value;
   logic [15:0]        chars_consumed;

   modport source (output valid, output status, output value, output chars_consumed,
                   input ready);
   modport sink (input valid, input status, input value, input chars_consumed,
                 output ready);
endinterface

`default_nettype wire

// ===== src/text_to_signed_integer.sv =====
// Streaming strtoll-style converter. One character is accepted per cycle on req_chan; the
// string_start flag opens a new string. Leading blanks, one sign and a radix prefix are
// consumed, then digits are accumulated until the first non-digit (NUL included), and one
// result per string appears on rsp_chan: the terminating character passes an input
// register, then the parse state machine with its 64 by 6 multiply-accumulate and bound
// compare, then the result register. Throughput is one item per cycle; a held result
// stalls only a character that produces another result. Bad base reports at the string
// start character. The user must write configuration registers through the csr_ port only
// while no string is in flight (not enforced). number_base is sampled at string start.
// depends on tti_pkg, tti_req_if, tti_rsp_if, tti_csr, tti_parser and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "text_to_signed_integer_assert.svh"

module text_to_signed_integer
   import tti_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tti_req_if.sink          req_chan,
   tti_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   cfg_type    cfg;
   result_type res;

   logic       in_valid_ff;
   logic       in_start_ff;
   logic [7:0] in_char_ff;
   logic       step;
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [63:0] rsp_value_ff;
   logic [15:0] rsp_chars_ff;

   tti_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tti_parser #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .string_start (in_start_ff),
      .character    (in_char_ff),
      .cfg          (cfg),
      .res          (res)
   );

   assign step = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready || !res.emit);
   assign req_chan.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_start_ff <= req_chan.string_start;
         in_char_ff <= req_chan.character;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.emit) begin
         rsp_status_ff <= res.status;
         rsp_value_ff <= res.value;
         rsp_chars_ff <= res.chars_consumed;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.value = rsp_value_ff;
   assign rsp_chan.chars_consumed = rsp_chars_ff;

   `TTI_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready, !(step && res.emit))
   `TTI_ASSERT_IMPLY(a_bad_base_zero, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_BAD_BASE, rsp_value_ff == 64'd0 && rsp_chars_ff == 16'd0)
   `TTI_ASSERT_IMPLY(a_status_known, clock, reset, rsp_valid_ff, rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_BAD_BASE || rsp_status_ff == STATUS_RANGE)

endmodule

`default_nettype wire

// ===== src/tti_csr.sv =====
// configuration registers: base, bounds and digit limit
// depends on tti_pkg
`timescale 1ns / 1ps
`default_nettype none

module tti_csr
   import tti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NUMBER_BASE:   cfg_in.number_base = csr_write_data[5:0];
            CSR_LOWEST_VALUE:  cfg_in.lowest_value = csr_write_data;
            CSR_HIGHEST_VALUE: cfg_in.highest_value = csr_write_data[62:0];
            CSR_DIGIT_LIMIT:   cfg_in.digit_limit = csr_write_data[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.number_base <= BASE_DECIMAL;
         cfg_ff.lowest_value <= RESET_LOWEST_VALUE;
         cfg_ff.highest_value <= RESET_HIGHEST_VALUE;
         cfg_ff.digit_limit <= RESET_DIGIT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/tti_digit.sv =====
// digit decode, multiply-accumulate and range check for one character
// depends on tti_pkg
`timescale 1ns / 1ps
`default_nettype none

module tti_digit
   import tti_pkg::*;
(
   input  wire logic [7:0]  character,
   input  wire logic [5:0]  base,
   input  wire logic [63:0] acc,
   input  wire logic [6:0]  digit_count,
   input  wire logic        negative,
   input  cfg_type          cfg,
   output digit_type        digit
);

   logic [5:0]  digit_value;
   logic [69:0] product;
   logic [70:0] sum;
   logic [63:0] bound;

   always_comb begin
      if (character inside {[CHAR_ZERO:CHAR_NINE]}) begin
         digit_value = 6'(character - CHAR_ZERO);
      end else if (character inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         digit_value = 6'(character - CHAR_LOWER_A) + LETTER_OFFSET;
      end else if (character inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         digit_value = 6'(character - CHAR_UPPER_A) + LETTER_OFFSET;
      end else begin
         digit_value = DIGIT_NONE;
      end
   end

   assign product = {6'd0, acc} * {64'd0, base};
   assign sum = {1'b0, product} + {65'd0, digit_value};
   assign bound = negative ? (64'd0 - cfg.lowest_value) : {1'b0, cfg.highest_value};

   assign digit.stop = (digit_value >= base);
   assign digit.range_error = (|sum[70:64]) || (sum[63:0] > bound) ||
                              (digit_count >= cfg.digit_limit);
   assign digit.next_acc = sum[63:0];

endmodule

`default_nettype wire

// ===== src/tti_parser.sv =====
// parse state machine: blanks, sign, radix prefix and digit accumulation
// depends on tti_pkg, tti_digit and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "text_to_signed_integer_assert.svh"

module tti_parser
   import tti_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       string_start,
   input  wire logic [7:0] character,
   input  cfg_type         cfg,
   output result_type      res
);

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_BAD_BASE,
      ACT_BLANK,
      ACT_SIGN,
      ACT_ZERO,
      ACT_PREFIX_X,
      ACT_DIGIT
   } action_type;

   phase_type                phase_ff, phase_in;
   logic                     neg_ff, neg_in;
   logic [5:0]               base_ff, base_in;
   logic [63:0]              acc_ff, acc_in;
   logic [6:0]               count_ff, count_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   phase_type                eff_phase;
   logic                     eff_neg;
   logic [5:0]               eff_base;
   logic [63:0]              eff_acc;
   logic [6:0]               eff_count;
   logic [POSITION_BITS-1:0] eff_pos;
   logic [POSITION_BITS-1:0] pos_next;
   logic                     bad_base;
   logic                     prefix_ok;
   logic [5:0]               digit_base;
   action_type               action;
   digit_type                digit;

   always_comb begin
      eff_phase = string_start ? PH_LEAD : phase_ff;
      eff_neg = string_start ? 1'b0 : neg_ff;
      eff_base = string_start ? cfg.number_base : base_ff;
      eff_acc = string_start ? 64'd0 : acc_ff;
      eff_count = string_start ? 7'd0 : count_ff;
      eff_pos = string_start ? '0 : pos_ff;
      bad_base = string_start &&
                 (cfg.number_base == BASE_UNARY || cfg.number_base > BASE_MAX);
      pos_next = (eff_pos == '1) ? eff_pos : eff_pos + 1'b1;
      prefix_ok = (eff_base == BASE_DETECT || eff_base == BASE_HEX) &&
                  (character == CHAR_ZERO);
   end

   // action and the base a digit is read in
   always_comb begin
      action = ACT_NONE;
      digit_base = eff_base;
      if (bad_base) begin
         action = ACT_BAD_BASE;
      end else begin
         case (eff_phase)
            PH_LEAD: begin
               if (character inside {CHAR_SPACE, CHAR_TAB}) begin
                  action = ACT_BLANK;
               end else if (character inside {CHAR_PLUS, CHAR_MINUS}) begin
                  action = ACT_SIGN;
               end else if (prefix_ok) begin
                  action = ACT_ZERO;
               end else begin
                  action = ACT_DIGIT;
                  digit_base = (eff_base == BASE_DETECT) ? BASE_DECIMAL : eff_base;
               end
            end
            PH_SIGNED: begin
               if (prefix_ok) begin
                  action = ACT_ZERO;
               end else begin
                  action = ACT_DIGIT;
                  digit_base = (eff_base == BASE_DETECT) ? BASE_DECIMAL : eff_base;
               end
            end
            PH_ZERO: begin
               if (character inside {CHAR_LOWER_X, CHAR_UPPER_X}) begin
                  action = ACT_PREFIX_X;
               end else begin
                  action = ACT_DIGIT;
                  digit_base = (eff_base == BASE_DETECT) ? BASE_OCTAL : eff_base;
               end
            end
            PH_DIGITS: action = ACT_DIGIT;
            default:   action = ACT_NONE;
         endcase
      end
   end

   tti_digit u_digit (
      .character   (character),
      .base        (digit_base),
      .acc         (eff_acc),
      .digit_count (eff_count),
      .negative    (eff_neg),
      .cfg         (cfg),
      .digit       (digit)
   );

   // next state
   always_comb begin
      case (action)
         ACT_BAD_BASE: phase_in = PH_DONE;
         ACT_BLANK:    phase_in = PH_LEAD;
         ACT_SIGN:     phase_in = PH_SIGNED;
         ACT_ZERO:     phase_in = PH_ZERO;
         ACT_PREFIX_X: phase_in = PH_DIGITS;
         ACT_DIGIT:    phase_in = (digit.stop || digit.range_error) ? PH_DONE : PH_DIGITS;
         default:      phase_in = phase_ff;
      endcase
   end

   // datapath and result
   always_comb begin
      neg_in = eff_neg;
      base_in = eff_base;
      acc_in = eff_acc;
      count_in = eff_count;
      pos_in = eff_pos;
      res.emit = 1'b0;
      res.status = STATUS_OK;
      res.value = 64'd0;
      res.chars_consumed = 16'(eff_pos);
      case (action)
         ACT_BAD_BASE: begin
            base_in = BASE_DETECT;
            res.emit = 1'b1;
            res.status = STATUS_BAD_BASE;
            res.chars_consumed = 16'd0;
         end
         ACT_BLANK: pos_in = pos_next;
         ACT_SIGN: begin
            neg_in = (character == CHAR_MINUS);
            pos_in = pos_next;
         end
         ACT_ZERO: pos_in = pos_next;
         ACT_PREFIX_X: begin
            base_in = BASE_HEX;
            pos_in = pos_next;
         end
         ACT_DIGIT: begin
            base_in = digit_base;
            if (digit.stop) begin
               res.emit = 1'b1;
               res.value = eff_neg ? (64'd0 - eff_acc) : eff_acc;
            end else if (digit.range_error) begin
               res.emit = 1'b1;
               res.status = STATUS_RANGE;
               res.value = eff_neg ? cfg.lowest_value : {1'b0, cfg.highest_value};
               res.chars_consumed = 16'(pos_next);
            end else begin
               acc_in = digit.next_acc;
               count_in = eff_count + 7'd1;
               pos_in = pos_next;
            end
         end
         default: res.emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         neg_ff <= 1'b0;
         base_ff <= BASE_DETECT;
         acc_ff <= 64'd0;
         count_ff <= 7'd0;
         pos_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         neg_ff <= neg_in;
         base_ff <= base_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
      end
   end

   `TTI_ASSERT_NEXT(a_emit_ends_string, clock, reset, step && res.emit, phase_ff == PH_DONE)
   `TTI_ASSERT_IMPLY(a_digits_have_base, clock, reset, phase_ff == PH_DIGITS, base_ff >= 6'd2 && base_ff <= BASE_MAX)
   `TTI_ASSERT_IMPLY(a_zero_prefix_base, clock, reset, phase_ff == PH_ZERO, base_ff == BASE_DETECT || base_ff == BASE_HEX)

endmodule

`default_nettype wire
